/* sv/lggs_pkg.sv */
// lggs_pkg: shared constants and types for the life grid generation step block
// command codes, field widths and default grid size
// no dependencies
`timescale 1ns / 1ps

package lggs_pkg;

    // default interior grid size
    localparam int GRID_W_DEF = 96;
    localparam int GRID_H_DEF = 68;

    // field widths
    localparam int CMD_W       = 2;
    localparam int COORD_W     = 7;
    localparam int GEN_W       = 32;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    // b3/s23 rule counts
    localparam int LIFE_BIRTH   = 3;
    localparam int LIFE_SURVIVE = 2;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_WRITE = 2'd0;
    localparam t_cmd CMD_READ  = 2'd1;
    localparam t_cmd CMD_STEP  = 2'd2;

endpackage

/* sv/life_grid_generation_step.sv */
// life_grid_generation_step: b3/s23 cell grid held in a column-wide memory
// sequence: an in-grid write or read reads its column word, then updates or samples it, then
// loads the result word; off-grid or unused loads it at once; a step reads one memory word
// per column of GRID_W + 2 in turn, then loads the result word; one word at a time, the next
// accept waits for the idle state; a stalled result word holds off the next one
// reset: synchronous active low; clears control, per-column valid bits make the grid read dead
`timescale 1ns / 1ps

module life_grid_generation_step #(
    parameter int GRID_W = lggs_pkg::GRID_W_DEF,
    parameter int GRID_H = lggs_pkg::GRID_H_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // command [1:0], cell_x [8:2], cell_y [15:9], cell_in [16], zero pad [23:17]
    input  logic [lggs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // cell_value [0], generation [32:1], zero pad [39:33]
    output logic [lggs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // grid geometry with the border ring
    localparam int COLS = GRID_W + 2;
    localparam int ROWS = GRID_H + 2;
    localparam int AW   = $clog2(COLS);      // column address
    localparam int RW   = $clog2(ROWS);      // row index
    localparam int CW   = $clog2(COLS + 1);  // sweep counter, reaches COLS
    localparam int MCW  = $clog2(GRID_W);    // mutation column
    localparam int MRW  = $clog2(GRID_H);    // mutation row
    localparam int GW   = lggs_pkg::GEN_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // grid memory: one word per column, bit index is the row
    logic [ROWS-1:0] r_mem [COLS];

    // control state
    logic [2:0]       r_state;
    logic [CW-1:0]    r_cnt;
    logic [COLS-1:0]  r_vld;          // column written since reset
    logic [MCW-1:0]   r_mcol;
    logic [MRW-1:0]   r_mrow;
    logic [GW-1:0]    r_gen;
    logic             r_out_valid;

    // payload
    logic [ROWS-1:0]  r_rdata;
    logic             r_rd_vld;
    logic [ROWS-1:0]  r_left;
    logic [ROWS-1:0]  r_mid;
    logic [AW-1:0]    r_x;
    logic [RW-1:0]    r_y;
    logic             r_cin;
    logic             r_pend;
    logic             r_out_cell;
    logic [GW-1:0]    r_out_gen;

    // input word fields
    lggs_pkg::t_cmd                in_cmd;
    logic [lggs_pkg::COORD_W-1:0]  in_x;
    logic [lggs_pkg::COORD_W-1:0]  in_y;
    logic                          in_cin;
    logic                          in_grid;
    logic                          accept;

    assign in_cmd = s_axis_tdata[1:0];
    assign in_x   = s_axis_tdata[8:2];
    assign in_y   = s_axis_tdata[15:9];
    assign in_cin = s_axis_tdata[16];

    assign in_grid       = (int'(in_x) < COLS) && (int'(in_y) < ROWS);
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // next mutation point, swept along each row with the column fastest
    logic [MCW-1:0] n_mcol;
    logic [MRW-1:0] n_mrow;

    always_comb begin
        n_mcol = (r_mcol == MCW'(GRID_W - 1)) ? '0 : r_mcol + MCW'(1);
        n_mrow = r_mrow;
        if (n_mcol == '0) begin
            n_mrow = (r_mrow == MRW'(GRID_H - 1)) ? '0 : r_mrow + MRW'(1);
        end
    end

    // read port control
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (r_state == S_IDLE) begin
            if (in_cmd == lggs_pkg::CMD_STEP) begin
                rd_en = accept;
            end else begin
                rd_en   = accept && in_grid &&
                          (in_cmd == lggs_pkg::CMD_WRITE || in_cmd == lggs_pkg::CMD_READ);
                rd_addr = AW'(in_x);
            end
        end else if (r_state == S_STEP) begin
            rd_en   = (r_cnt < CW'(COLS));
            rd_addr = r_cnt[AW-1:0];
        end
    end

    // column just read; never-written columns read dead
    logic [ROWS-1:0] col_data;
    assign col_data = r_rd_vld ? r_rdata : '0;

    // mutation cell sits in column mcol+1, which arrives when the counter is mcol+2
    logic            mut_hit;
    logic [ROWS-1:0] mut_mask;
    logic [ROWS-1:0] col_right;

    assign mut_hit = (r_cnt == CW'(r_mcol) + CW'(2));

    always_comb begin
        mut_mask = '0;
        mut_mask[RW'(r_mrow) + RW'(1)] = 1'b1;
    end

    assign col_right = col_data | (mut_hit ? mut_mask : '0);

    // next generation of the middle column, border rows kept
    logic [ROWS-1:0] new_col;

    always_comb begin
        logic [3:0] n;
        new_col = r_mid;
        for (int r = 1; r < ROWS - 1; r++) begin
            n = 4'(r_left[r-1]) + 4'(r_left[r]) + 4'(r_left[r+1])
              + 4'(r_mid[r-1]) + 4'(r_mid[r+1])
              + 4'(col_right[r-1]) + 4'(col_right[r]) + 4'(col_right[r+1]);
            new_col[r] = (n == 4'(lggs_pkg::LIFE_BIRTH)) ||
                         ((n == 4'(lggs_pkg::LIFE_SURVIVE)) && r_mid[r]);
        end
    end

    // single-cell update of the column word
    logic [ROWS-1:0] wr_word;

    always_comb begin
        wr_word       = col_data;
        wr_word[r_y]  = r_cin;
    end

    // write port control; a step writes column cnt-2 while reading column cnt
    logic            we;
    logic [AW-1:0]   wr_addr;
    logic [ROWS-1:0] wr_data;

    always_comb begin
        we      = 1'b0;
        wr_addr = r_x;
        wr_data = wr_word;
        if (r_state == S_WRITE) begin
            we = 1'b1;
        end else if (r_state == S_STEP) begin
            we      = (r_cnt >= CW'(3));
            wr_addr = AW'(r_cnt - CW'(2));
            wr_data = new_col;
        end
    end

    // grid memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_vld       <= '0;
            r_mcol      <= '0;
            r_mrow      <= '0;
            r_gen       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a finished word, or empty the register once it is taken
            if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (we) begin
                r_vld[wr_addr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (in_cmd)
                            lggs_pkg::CMD_WRITE: begin
                                r_state <= in_grid ? S_WRITE : S_DONE;
                            end
                            lggs_pkg::CMD_READ: begin
                                r_state <= in_grid ? S_READ : S_DONE;
                            end
                            lggs_pkg::CMD_STEP: begin
                                r_state <= S_STEP;
                                r_cnt   <= CW'(1);
                                r_mcol  <= n_mcol;
                                r_mrow  <= n_mrow;
                                r_gen   <= r_gen + GW'(1);
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_WRITE, S_READ: begin
                    r_state <= S_DONE;
                end
                S_STEP: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(COLS)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // wait for the output register to be free
                    if (!r_out_valid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_vld <= r_vld[rd_addr];
        end
        if (accept) begin
            r_x    <= AW'(in_x);
            r_y    <= RW'(in_y);
            r_cin  <= in_cin;
            r_pend <= 1'b0;
        end
        if (r_state == S_READ) begin
            r_pend <= col_data[r_y];
        end
        if (r_state == S_STEP) begin
            // three-column window slides one column per cycle
            r_left <= r_mid;
            r_mid  <= col_right;
        end
        if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_cell <= r_pend;
            r_out_gen  <= r_gen;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(lggs_pkg::OUT_TDATA_W - GW - 1)'(0), r_out_gen, r_out_cell};

endmodule

/* sv/lggs_checker.sv */
// lggs_checker: port-level assertions for life_grid_generation_step
// bound to the top level below; depends on lggs_pkg
`timescale 1ns / 1ps

module lggs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [lggs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [lggs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one word at a time: busy the cycle after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on back-to-back cycles");

    // pad bits of the result word stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[lggs_pkg::OUT_TDATA_W-1:lggs_pkg::GEN_W+1] == '0)
        else $error("result pad bits set");

    // no second input word is accepted in the cycle after an accept
    a_no_accept_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !(s_axis_tvalid && s_axis_tready))
        else $error("second word accepted while first in flight");

endmodule

bind life_grid_generation_step lggs_checker u_lggs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
